// ===== hdl/rpn_stack_evaluator_macros.svh =====
// rpn_stack_evaluator_macros.svh: assertion macros shared by the RPN evaluator RTL.
// Uses the clk and rst_n names of the module that includes it.
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

// Clocked check, off while reset is asserted.
`define RPN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true at a clock edge.
`define RPN_NEVER(label, cond, msg) \
    `RPN_ASSERT(label, !(cond), msg)

`endif

// ===== hdl/rpn_pkg.sv =====
// rpn_pkg: widths, token kinds, status codes and stack cell codes of the RPN evaluator.
// No dependencies; imported by every module of the block.
`default_nettype none

package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_WIDTH + 1);

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [CNT_W-1:0]             count_t;
    typedef logic [2:0]                   kind_t;
    typedef logic [2:0]                   status_t;
    typedef logic [1:0]                   cell_op_t;

    localparam kind_t KIND_NUM = 3'd0;
    localparam kind_t KIND_ADD = 3'd1;
    localparam kind_t KIND_SUB = 3'd2;
    localparam kind_t KIND_MUL = 3'd3;
    localparam kind_t KIND_DIV = 3'd4;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_UNDER   = 3'd1;
    localparam status_t ST_OVER    = 3'd2;
    localparam status_t ST_DIVZERO = 3'd3;
    localparam status_t ST_EMPTY   = 3'd4;

    // hold, take the neighbor nearer the top, take the neighbor further down
    localparam cell_op_t CELL_HOLD    = 2'd0;
    localparam cell_op_t CELL_FROM_UP = 2'd1;
    localparam cell_op_t CELL_FROM_DN = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/rpn_stack_evaluator.sv =====
// rpn_stack_evaluator: postfix integer expression evaluator on a shifting chain of stack cells.
// Depends on rpn_pkg, rpn_cell, rpn_div and the assertion macros header.
//
//   channel  signals                          direction  accepted when
//   in       kind, operand_value, last        into block in_valid && !in_stall
//   out      expression_value, status         out of     out_valid && !out_stall
//
// A number, add, subtract or unknown token passes through S_EXEC, multiply also through S_MULW,
// divide waits in S_DIV while the divider makes one quotient bit per cycle; the token marked
// last then goes through S_DONE to load the output register. Tokens are taken only in S_IDLE.
// Reset clears the stack count, the error status and the output valid; stack cells keep
// whatever they hold and are only read below the count.
// A waiting result does not block new tokens; only the next last token waits for the
// output register to free up.
`default_nettype none
`include "rpn_stack_evaluator_macros.svh"

module rpn_stack_evaluator (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  rpn_pkg::kind_t        kind,
    input  rpn_pkg::data_t        operand_value,
    input  wire                   last,
    output logic                  out_valid,
    input  wire                   out_stall,
    output rpn_pkg::data_t        expression_value,
    output rpn_pkg::status_t      status
);
    import rpn_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MULW = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    count_t     count_reg;
    count_t     count_next;
    status_t    err_reg;
    status_t    err_next;

    kind_t      tok_kind_reg;
    data_t      tok_val_reg;
    logic       tok_last_reg;
    logic       tok_take;

    data_t      prod_reg;
    data_t      mul_lo;

    logic       out_valid_reg;
    logic       out_valid_next;
    data_t      expression_value_reg;
    status_t    status_reg;
    logic       out_load;

    logic       push;
    logic       pop;
    data_t      head_data;
    logic       div_start;
    logic       div_done;
    data_t      div_quo;

    data_t      cell_q [STACK_DEPTH];
    cell_op_t   op_top;
    cell_op_t   op_rest;

    data_t      right_val;
    data_t      left_val;
    status_t    fin_status;
    data_t      fin_value;

    assign right_val = cell_q[0];
    assign left_val  = cell_q[1];
    assign mul_lo    = DATA_WIDTH'(left_val * right_val);

    // top cell loads the head value on both push and pop; the rest shift
    assign op_top  = (push || pop) ? CELL_FROM_UP : CELL_HOLD;
    assign op_rest = push ? CELL_FROM_UP : (pop ? CELL_FROM_DN : CELL_HOLD);

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            data_t    up_w;
            data_t    dn_w;
            cell_op_t op_w;
            if (gi == 0)
            begin : g_top
                assign up_w = head_data;
                assign op_w = op_top;
            end
            else
            begin : g_mid
                assign up_w = cell_q[gi-1];
                assign op_w = op_rest;
            end
            if (gi == STACK_DEPTH - 1)
            begin : g_bottom
                assign dn_w = '0;
            end
            else
            begin : g_link
                assign dn_w = cell_q[gi+1];
            end
            rpn_cell u_cell (
                .clk     (clk),
                .op      (op_w),
                .from_up (up_w),
                .from_dn (dn_w),
                .value   (cell_q[gi])
            );
        end
    endgenerate

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (left_val),
        .divisor  (right_val),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign fin_status = (err_reg != ST_OK) ? err_reg :
                        ((count_reg == '0) ? ST_EMPTY : ST_OK);
    assign fin_value  = (fin_status == ST_OK) ? cell_q[0] : '0;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        err_next   = err_reg;
        push       = 1'b0;
        pop        = 1'b0;
        head_data  = tok_val_reg;
        div_start  = 1'b0;
        tok_take   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tok_take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = tok_last_reg ? S_DONE : S_IDLE;
                // after an error, drop tokens until the last one
                if (err_reg == ST_OK)
                begin
                    case (tok_kind_reg)
                        KIND_NUM:
                        begin
                            if (count_reg == CNT_W'(STACK_DEPTH))
                            begin
                                err_next = ST_OVER;
                            end
                            else
                            begin
                                push       = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                err_next = ST_UNDER;
                            end
                            else if (tok_kind_reg == KIND_MUL)
                            begin
                                state_next = S_MULW;
                            end
                            else if (tok_kind_reg == KIND_DIV)
                            begin
                                if (right_val == '0)
                                begin
                                    err_next = ST_DIVZERO;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                end
                            end
                            else
                            begin
                                pop        = 1'b1;
                                count_next = count_reg - 1'b1;
                                head_data  = (tok_kind_reg == KIND_ADD) ?
                                             (left_val + right_val) : (left_val - right_val);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MULW:
            begin
                pop        = 1'b1;
                count_next = count_reg - 1'b1;
                head_data  = prod_reg;
                state_next = tok_last_reg ? S_DONE : S_IDLE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pop        = 1'b1;
                    count_next = count_reg - 1'b1;
                    head_data  = div_quo;
                    state_next = tok_last_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free, then empty the stack
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    count_next = '0;
                    err_next   = ST_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_take)
        begin
            tok_kind_reg <= kind;
            tok_val_reg  <= operand_value;
            tok_last_reg <= last;
        end
        if (state_reg == S_EXEC)
        begin
            prod_reg <= mul_lo;
        end
        if (out_load)
        begin
            expression_value_reg <= fin_value;
            status_reg           <= fin_status;
        end
    end

    assign out_valid        = out_valid_reg;
    assign expression_value = expression_value_reg;
    assign status           = status_reg;

    `RPN_ASSERT(a_count_in_range, count_reg <= CNT_W'(STACK_DEPTH), "stack count above depth")
    `RPN_ASSERT(a_error_freezes_stack, (err_reg != ST_OK && state_reg != S_DONE) |=> $stable(count_reg), "stack moved after an error")
    `RPN_ASSERT(a_done_clears, out_load |=> (count_reg == '0 && err_reg == ST_OK && out_valid_reg), "expression end did not clear the stack")
    `RPN_NEVER(a_div_done_state, div_done && state_reg != S_DIV, "divider finished outside the divide step")

endmodule

`default_nettype wire

// ===== hdl/rpn_cell.sv =====
// rpn_cell: one entry of the shifting operand stack.
// Depends on rpn_pkg for the data type and cell codes.
`default_nettype none

module rpn_cell (
    input  wire              clk,
    input  rpn_pkg::cell_op_t op,
    input  rpn_pkg::data_t   from_up,
    input  rpn_pkg::data_t   from_dn,
    output rpn_pkg::data_t   value
);
    import rpn_pkg::*;

    data_t value_reg;
    data_t value_next;

    always_comb
    begin
        case (op)
            CELL_FROM_UP: value_next = from_up;
            CELL_FROM_DN: value_next = from_dn;
            default:      value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== hdl/rpn_div.sv =====
// rpn_div: iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg and the assertion macros header.
`default_nettype none
`include "rpn_stack_evaluator_macros.svh"

module rpn_div (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             start,
    input  rpn_pkg::data_t  dividend,
    input  rpn_pkg::data_t  divisor,
    output logic            done,
    output rpn_pkg::data_t  quotient
);
    import rpn_pkg::*;

    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;
    logic [DATA_WIDTH-1:0]  rem_reg;
    logic [DATA_WIDTH-1:0]  rem_next;
    logic [DATA_WIDTH-1:0]  quo_reg;
    logic [DATA_WIDTH-1:0]  quo_next;
    logic [DATA_WIDTH-1:0]  dsr_reg;
    logic [DATA_WIDTH-1:0]  dsr_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [DATA_WIDTH-1:0]  mag_a;
    logic [DATA_WIDTH-1:0]  mag_b;
    logic [DATA_WIDTH:0]    shifted;
    logic [DATA_WIDTH:0]    trial;

    assign mag_a   = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b   = divisor[DATA_WIDTH-1]  ? (~divisor + 1'b1)  : divisor;
    assign shifted = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DATA_WIDTH);
            rem_next  = '0;
            quo_next  = mag_a;
            dsr_next  = mag_b;
            neg_next  = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
        end
        else if (busy_reg)
        begin
            // restoring step: keep the difference when it did not go negative
            if (!trial[DATA_WIDTH])
            begin
                rem_next = trial[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? data_t'(~quo_reg + 1'b1) : data_t'(quo_reg);

    `RPN_NEVER(a_div_done_while_busy, done_reg && busy_reg, "divider done while still busy")
    `RPN_NEVER(a_div_start_while_busy, start && busy_reg, "divider started while busy")
    `RPN_ASSERT(a_div_done_after_run, $fell(busy_reg) |-> done_reg, "divider run ended without done")

endmodule

`default_nettype wire
